FILE: sv/ips_patch_stream_decoder_macros.svh
// Assertion shorthands used by the checker of this block.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef IPS_PATCH_STREAM_DECODER_MACROS_SVH
`define IPS_PATCH_STREAM_DECODER_MACROS_SVH

// Clocked property, switched off while reset is held.
`define IPSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define IPSD_NEVER(label, expr, msg) \
    `IPSD_ASSERT(label, !(expr), msg)

`endif

FILE: sv/ipsd_pkg.sv
`timescale 1ns / 1ps

package ipsd_pkg;

    typedef enum logic [2:0] {
        KIND_WRITE     = 3'd0,
        KIND_FILL      = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_BAD_MAGIC = 3'd3,
        KIND_NO_MARK   = 3'd4
    } t_kind;

    // One queue entry: everything a single patch byte gives rise to.
    typedef struct packed {
        logic         has_cmd;
        t_kind        cmd_kind;
        logic [31:0]  address;
        logic [7:0]   value;
        logic [15:0]  fill_length;
        logic         has_status;
        t_kind        status_kind;
    } t_entry;

    localparam logic [31:0] MARK_IPS   = 32'h0045_4F46;   // "EOF"
    localparam logic [31:0] MARK_IPS32 = 32'h4545_4F46;   // "EEOF"

    localparam int IPSD_Q_DEPTH = 4;

    // Header bytes: "PATCH" for plain, "IPS32" for the extended format.
    function automatic logic [7:0] magic_byte(input logic ext, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            3'd0: b = ext ? 8'h49 : 8'h50;
            3'd1: b = ext ? 8'h50 : 8'h41;
            3'd2: b = ext ? 8'h53 : 8'h54;
            3'd3: b = ext ? 8'h33 : 8'h43;
            3'd4: b = ext ? 8'h32 : 8'h48;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/ipsd_if.sv
`timescale 1ns / 1ps

interface ipsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] patch_byte;
    logic       byte_last;

    modport source (output valid, patch_byte, byte_last, input ready);
    modport sink   (input valid, patch_byte, byte_last, output ready);
    modport mon    (input valid, ready, patch_byte, byte_last);
endinterface

interface ipsd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] address;
    logic [7:0]  value;
    logic [15:0] fill_length;
    logic        run_last;

    modport source (output valid, kind, address, value, fill_length, run_last, input ready);
    modport sink   (input valid, kind, address, value, fill_length, run_last, output ready);
    modport mon    (input valid, ready, kind, address, value, fill_length, run_last);
endinterface

interface ipsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] image_size;

    modport source (output valid, image_size, input ready);
    modport sink   (input valid, image_size, output ready);
    modport mon    (input valid, ready, image_size);
endinterface

FILE: sv/ipsd_front.sv
`timescale 1ns / 1ps

module ipsd_front
    import ipsd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ipsd_in_if.sink      i_patch,
    input  logic [31:0]  i_image_size,
    input  logic         i_q_full,
    output logic         o_push,
    output t_entry       o_entry
);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_OFFSET,
        PH_SIZE,
        PH_RUNLEN,
        PH_RUNVAL,
        PH_DATA,
        PH_DRAIN
    } t_phase;

    t_phase       r_phase,   n_phase;
    logic         r_ext,     n_ext;
    logic [2:0]   r_cnt,     n_cnt;
    logic [31:0]  r_offset,  n_offset;
    logic [15:0]  r_remain,  n_remain;   // size, run length or data bytes left
    logic [32:0]  r_pos,     n_pos;      // no wrap: past 2^32-1 is off the image
    logic         r_match_p, n_match_p;
    logic         r_match_e, n_match_e;

    logic         acc;
    logic         terminal;
    logic         mp, me;
    logic [32:0]  room;
    logic [15:0]  fill_len;
    logic [7:0]   b;
    t_entry       e;

    assign i_patch.ready = !i_q_full;
    assign acc = i_patch.valid && !i_q_full;
    assign b   = i_patch.patch_byte;

    assign mp = r_match_p && (b == magic_byte(1'b0, r_cnt));
    assign me = r_match_e && (b == magic_byte(1'b1, r_cnt));

    // Space left in the image from the record offset; borrow means none.
    assign room = {1'b0, i_image_size} - {1'b0, r_offset};

    always_comb begin
        if (room[32]) begin
            fill_len = '0;
        end else if (room[31:0] < {16'd0, r_remain}) begin
            fill_len = room[15:0];
        end else begin
            fill_len = r_remain;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_ext     = r_ext;
        n_cnt     = r_cnt;
        n_offset  = r_offset;
        n_remain  = r_remain;
        n_pos     = r_pos;
        n_match_p = r_match_p;
        n_match_e = r_match_e;
        terminal  = 1'b0;
        e         = '0;

        if (acc) begin
            case (r_phase)
                PH_MAGIC: begin
                    n_match_p = mp;
                    n_match_e = me;
                    if (r_cnt == 3'd4) begin
                        n_cnt = '0;
                        if (!mp && !me) begin
                            e.has_status  = 1'b1;
                            e.status_kind = KIND_BAD_MAGIC;
                            terminal      = 1'b1;
                            n_phase       = PH_DRAIN;
                        end else begin
                            n_ext    = me;
                            n_offset = '0;
                            n_phase  = PH_OFFSET;
                        end
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
                PH_OFFSET: begin
                    n_offset = {r_offset[23:0], b};
                    n_cnt    = r_cnt + 3'd1;
                    if (r_cnt == (r_ext ? 3'd3 : 3'd2)) begin
                        n_cnt = '0;
                        if (n_offset == (r_ext ? MARK_IPS32 : MARK_IPS)) begin
                            e.has_status  = 1'b1;
                            e.status_kind = KIND_DONE;
                            terminal      = 1'b1;
                            n_phase       = PH_DRAIN;
                        end else begin
                            n_remain = '0;
                            n_phase  = PH_SIZE;
                        end
                    end
                end
                PH_SIZE: begin
                    n_remain = {r_remain[7:0], b};
                    n_cnt    = r_cnt + 3'd1;
                    if (r_cnt == 3'd1) begin
                        n_cnt = '0;
                        if (n_remain == 16'd0) begin
                            n_phase = PH_RUNLEN;
                        end else begin
                            n_pos   = {1'b0, r_offset};
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_RUNLEN: begin
                    n_remain = {r_remain[7:0], b};
                    n_cnt    = r_cnt + 3'd1;
                    if (r_cnt == 3'd1) begin
                        n_cnt   = '0;
                        n_phase = PH_RUNVAL;
                    end
                end
                PH_RUNVAL: begin
                    e.has_cmd     = 1'b1;
                    e.cmd_kind    = KIND_FILL;
                    e.address     = r_offset;
                    e.value       = b;
                    e.fill_length = fill_len;
                    n_remain      = '0;
                    n_offset      = '0;
                    n_phase       = PH_OFFSET;
                end
                PH_DATA: begin
                    if (r_pos < {1'b0, i_image_size}) begin
                        e.has_cmd  = 1'b1;
                        e.cmd_kind = KIND_WRITE;
                        e.address  = r_pos[31:0];
                        e.value    = b;
                    end
                    n_pos    = r_pos + 33'd1;
                    n_remain = r_remain - 16'd1;
                    if (n_remain == 16'd0) begin
                        n_offset = '0;
                        n_phase  = PH_OFFSET;
                    end
                end
                default: begin
                    terminal = 1'b1;
                end
            endcase

            if (i_patch.byte_last) begin
                if (!terminal) begin
                    e.has_status  = 1'b1;
                    e.status_kind = (n_phase == PH_MAGIC) ? KIND_BAD_MAGIC : KIND_NO_MARK;
                end
                // next byte opens a fresh patch
                n_phase   = PH_MAGIC;
                n_ext     = 1'b0;
                n_cnt     = '0;
                n_offset  = '0;
                n_remain  = '0;
                n_pos     = '0;
                n_match_p = 1'b1;
                n_match_e = 1'b1;
            end else if (terminal) begin
                n_phase = PH_DRAIN;
            end
        end
    end

    assign o_push  = acc && (e.has_cmd || e.has_status);
    assign o_entry = e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAGIC;
            r_ext     <= 1'b0;
            r_cnt     <= '0;
            r_offset  <= '0;
            r_remain  <= '0;
            r_pos     <= '0;
            r_match_p <= 1'b1;
            r_match_e <= 1'b1;
        end else begin
            r_phase   <= n_phase;
            r_ext     <= n_ext;
            r_cnt     <= n_cnt;
            r_offset  <= n_offset;
            r_remain  <= n_remain;
            r_pos     <= n_pos;
            r_match_p <= n_match_p;
            r_match_e <= n_match_e;
        end
    end

endmodule

FILE: sv/ipsd_q.sv
`timescale 1ns / 1ps

module ipsd_q
    import ipsd_pkg::*;
#(
    parameter int DEPTH = IPSD_Q_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_entry  o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count + CW'(i_push) - CW'(i_pop);
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

FILE: sv/ipsd_back.sv
`timescale 1ns / 1ps

module ipsd_back
    import ipsd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    input  t_entry       i_head,
    output logic         o_pop,
    ipsd_out_if.source   o_cmd
);

    logic         r_valid;
    logic         r_half;       // head's command already sent, status pending
    t_kind        r_kind;
    logic [31:0]  r_address;
    logic [7:0]   r_value;
    logic [15:0]  r_fill_length;
    logic         r_run_last;

    logic         load;
    logic         send_cmd;

    assign load     = !r_valid || o_cmd.ready;
    assign send_cmd = i_head.has_cmd && !r_half;
    assign o_pop    = load && !i_empty && !(send_cmd && i_head.has_status);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_half <= send_cmd && i_head.has_status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            if (send_cmd) begin
                r_kind        <= i_head.cmd_kind;
                r_address     <= i_head.address;
                r_value       <= i_head.value;
                r_fill_length <= i_head.fill_length;
                r_run_last    <= !i_head.has_status;
            end else begin
                r_kind        <= i_head.status_kind;
                r_address     <= '0;
                r_value       <= '0;
                r_fill_length <= '0;
                r_run_last    <= 1'b1;
            end
        end
    end

    assign o_cmd.valid       = r_valid;
    assign o_cmd.kind        = r_kind;
    assign o_cmd.address     = r_address;
    assign o_cmd.value       = r_value;
    assign o_cmd.fill_length = r_fill_length;
    assign o_cmd.run_last    = r_run_last;

endmodule

FILE: sv/ips_patch_stream_decoder.sv
`timescale 1ns / 1ps
// A byte's first result is registered in the queue, then in the output register.
// Throughput: one patch byte per cycle while the queue has room; the output sends one
//   result per cycle unless stalled; a command and its closing status go out in turn.
// The result queue (Q_DEPTH entries) lets the parser run on while the output stalls.
// Reset: synchronous, active low; parser back to header, queue and output emptied,
//   image_size cleared to 0.

module ips_patch_stream_decoder
    import ipsd_pkg::*;
#(
    parameter int Q_DEPTH = IPSD_Q_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ipsd_cfg_if.sink     i_cfg,
    ipsd_in_if.sink      i_patch,
    ipsd_out_if.source   o_cmd
);

    logic [31:0]  r_image_size;
    logic         push, pop, q_full, q_empty;
    t_entry       push_entry, head;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= '0;
        end else if (i_cfg.valid) begin
            r_image_size <= i_cfg.image_size;
        end
    end

    ipsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_patch      (i_patch),
        .i_image_size (r_image_size),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    ipsd_q #(
        .DEPTH (Q_DEPTH)
    ) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    ipsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_cmd   (o_cmd)
    );

endmodule

FILE: sv/ipsd_chk.sv
`timescale 1ns / 1ps
`include "ips_patch_stream_decoder_macros.svh"

module ipsd_chk
    import ipsd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic         i_ready,
    input  logic [2:0]   i_kind,
    input  logic [31:0]  i_address,
    input  logic [7:0]   i_value,
    input  logic [15:0]  i_fill_length,
    input  logic         i_run_last
);

    logic is_status;

    assign is_status = (i_kind == KIND_DONE) || (i_kind == KIND_BAD_MAGIC) ||
                       (i_kind == KIND_NO_MARK);

    `IPSD_ASSERT(a_stall_hold, i_valid && !i_ready |=> i_valid && $stable({i_kind, i_address, i_value, i_fill_length, i_run_last}), "result beat changed while stalled")

    `IPSD_ASSERT(a_status_clean, i_valid && is_status |-> i_run_last && i_address == 32'd0 && i_value == 8'd0 && i_fill_length == 16'd0, "status beat not last or not zeroed")

    `IPSD_NEVER(a_write_len, i_valid && i_kind == KIND_WRITE && i_fill_length != 16'd0, "byte write carries a fill length")

    `IPSD_ASSERT(a_mid_run, i_valid && !i_run_last |-> i_kind == KIND_WRITE || i_kind == KIND_FILL, "non-final beat is not a command")

    `IPSD_ASSERT(a_status_follows, i_valid && i_ready && !i_run_last |=> i_valid && i_run_last && i_kind == KIND_NO_MARK, "command not followed by its closing status")

endmodule

bind ips_patch_stream_decoder ipsd_chk u_ipsd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_cmd.valid),
    .i_ready       (o_cmd.ready),
    .i_kind        (o_cmd.kind),
    .i_address     (o_cmd.address),
    .i_value       (o_cmd.value),
    .i_fill_length (o_cmd.fill_length),
    .i_run_last    (o_cmd.run_last)
);
